>>> design/lmlt_pkg.sv
// lcd mode and line timer: shared types, constants and register codes
// no dependencies; used by the register bank, the timer and the core

package lmlt_pkg;

  localparam logic [9:0] LINE_CYCLES    = 10'd456;
  localparam logic [7:0] VISIBLE_LINES  = 8'd144;
  localparam logic [7:0] LAST_LINE      = VISIBLE_LINES + 8'd9;
  localparam logic [9:0] OAM_THRESHOLD  = LINE_CYCLES - 10'd80;
  localparam logic [9:0] XFER_THRESHOLD = LINE_CYCLES - 10'd252;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } lcd_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DISPLAY_EN   = 3'd0,
    REG_BG_EN        = 3'd1,
    REG_SPRITE_EN    = 3'd2,
    REG_HBLANK_IRQ   = 3'd3,
    REG_VBLANK_IRQ   = 3'd4,
    REG_OAM_IRQ      = 3'd5,
    REG_COMPARE_IRQ  = 3'd6,
    REG_LINE_COMPARE = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic       display_enable;
    logic       background_enable;
    logic       sprite_enable;
    logic       hblank_irq_enable;
    logic       vblank_stat_irq_enable;
    logic       oam_irq_enable;
    logic       compare_irq_enable;
    logic [7:0] line_compare;
  } cfg_t;

  typedef struct packed {
    lcd_mode_e  lcd_mode;
    logic [7:0] line_now;
    logic       compare_match;
    logic       stat_irq;
    logic       vblank_irq;
    logic       draw_background;
    logic       draw_sprites;
    logic [7:0] drawn_line;
  } result_t;

endpackage

>>> design/lmlt_if.sv
// lcd mode and line timer: valid/ready channels for tick words and result words
// depends on nothing; field widths follow the block's word layout

interface lmlt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] elapsed_cycles;

  modport source (output valid, output elapsed_cycles, input ready);
  modport sink   (input valid, input elapsed_cycles, output ready);
endinterface

interface lmlt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] lcd_mode;
  logic [7:0] line_now;
  logic       compare_match;
  logic       stat_irq;
  logic       vblank_irq;
  logic       draw_background;
  logic       draw_sprites;
  logic [7:0] drawn_line;

  modport source (output valid, output lcd_mode, output line_now, output compare_match,
                  output stat_irq, output vblank_irq, output draw_background,
                  output draw_sprites, output drawn_line, input ready);
  modport sink   (input valid, input lcd_mode, input line_now, input compare_match,
                  input stat_irq, input vblank_irq, input draw_background,
                  input draw_sprites, input drawn_line, output ready);
endinterface

>>> design/lmlt_cfg_regs.sv
// lcd mode and line timer: configuration register bank
// depends on lmlt_pkg

module lmlt_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lmlt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lmlt_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output lmlt_pkg::cfg_t                  cfg_o
);

  lmlt_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (lmlt_pkg::cfg_idx_e'(cfg_idx_i))
        lmlt_pkg::REG_DISPLAY_EN:   cfg_d.display_enable         = cfg_wdata_i[0];
        lmlt_pkg::REG_BG_EN:        cfg_d.background_enable      = cfg_wdata_i[0];
        lmlt_pkg::REG_SPRITE_EN:    cfg_d.sprite_enable          = cfg_wdata_i[0];
        lmlt_pkg::REG_HBLANK_IRQ:   cfg_d.hblank_irq_enable      = cfg_wdata_i[0];
        lmlt_pkg::REG_VBLANK_IRQ:   cfg_d.vblank_stat_irq_enable = cfg_wdata_i[0];
        lmlt_pkg::REG_OAM_IRQ:      cfg_d.oam_irq_enable         = cfg_wdata_i[0];
        lmlt_pkg::REG_COMPARE_IRQ:  cfg_d.compare_irq_enable     = cfg_wdata_i[0];
        lmlt_pkg::REG_LINE_COMPARE: cfg_d.line_compare           = cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{display_enable: 1'b1, background_enable: 1'b1, default: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/lmlt_timer.sv
// lcd mode and line timer: line countdown, line counter, mode and compare state
// depends on lmlt_pkg; advances once per step_i and presents that step's result

module lmlt_timer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        cycles_i,
  input  lmlt_pkg::cfg_t    cfg_i,
  output lmlt_pkg::result_t res_o
);

  logic [9:0]           countdown_q, countdown_d;
  logic [7:0]           line_q, line_d;
  lmlt_pkg::lcd_mode_e  prev_mode_q, prev_mode_d;
  logic                 coinc_q, coinc_d;

  lmlt_pkg::lcd_mode_e  mode;
  logic                 req;
  logic                 line_match;
  logic [10:0]          remain;
  logic                 expired;

  always_comb begin
    // mode from line and countdown before this step's cycles are spent
    if (line_q >= lmlt_pkg::VISIBLE_LINES) begin
      mode = lmlt_pkg::MODE_VBLANK;
      req  = cfg_i.vblank_stat_irq_enable;
    end else if (countdown_q >= lmlt_pkg::OAM_THRESHOLD) begin
      mode = lmlt_pkg::MODE_OAM;
      req  = cfg_i.oam_irq_enable;
    end else if (countdown_q >= lmlt_pkg::XFER_THRESHOLD) begin
      mode = lmlt_pkg::MODE_XFER;
      req  = 1'b0;
    end else begin
      mode = lmlt_pkg::MODE_HBLANK;
      req  = cfg_i.hblank_irq_enable;
    end

    line_match = (line_q == cfg_i.line_compare);
    remain     = {1'b0, countdown_q} - {3'b000, cycles_i};
    // zero or negative remainder ends the line
    expired    = remain[10] | (remain == 11'd0);

    countdown_d = countdown_q;
    line_d      = line_q;
    prev_mode_d = prev_mode_q;
    coinc_d     = coinc_q;
    res_o       = '0;

    if (!cfg_i.display_enable) begin
      countdown_d         = lmlt_pkg::LINE_CYCLES;
      line_d              = 8'd0;
      prev_mode_d         = lmlt_pkg::MODE_VBLANK;
      res_o.lcd_mode      = lmlt_pkg::MODE_VBLANK;
      res_o.compare_match = coinc_q;
    end else begin
      prev_mode_d    = mode;
      coinc_d        = line_match;
      res_o.lcd_mode = mode;
      res_o.stat_irq = (req && (mode != prev_mode_q)) ||
                       (line_match && cfg_i.compare_irq_enable);
      res_o.compare_match = line_match;
      if (expired) begin
        // excess cycles carry into the next line
        countdown_d = remain[9:0] + lmlt_pkg::LINE_CYCLES;
        if (line_q == lmlt_pkg::VISIBLE_LINES) begin
          res_o.vblank_irq = 1'b1;
        end else if (line_q < lmlt_pkg::VISIBLE_LINES) begin
          res_o.draw_background = cfg_i.background_enable;
          res_o.draw_sprites    = cfg_i.sprite_enable;
          if (cfg_i.background_enable || cfg_i.sprite_enable) begin
            res_o.drawn_line = line_q;
          end
        end
        line_d = (line_q >= lmlt_pkg::LAST_LINE) ? 8'd0 : line_q + 8'd1;
      end else begin
        countdown_d = remain[9:0];
      end
      res_o.line_now = line_d;
    end
    if (!cfg_i.display_enable) begin
      res_o.line_now = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      countdown_q <= lmlt_pkg::LINE_CYCLES;
      line_q      <= 8'd0;
      prev_mode_q <= lmlt_pkg::MODE_OAM;
      coinc_q     <= 1'b0;
    end else if (step_i) begin
      countdown_q <= countdown_d;
      line_q      <= line_d;
      prev_mode_q <= prev_mode_d;
      coinc_q     <= coinc_d;
    end
  end

endmodule

>>> design/lcd_mode_and_line_timer_core.sv
// Tick words enter an input register, one step of the line timer runs on it, and the
// step's result lands in an output register. A word is accepted every cycle as long as
// the result side keeps taking words; a tick word waits in the input register until
// the output register is free or being read, then its result is registered there.
// Throughput is set by the single timer update per cycle (countdown subtract, mode
// compares and line increment). Configuration takes effect on the next word.
// Depends on lmlt_pkg, lmlt_if, lmlt_cfg_regs and lmlt_timer.

module lcd_mode_and_line_timer_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lmlt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lmlt_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  lmlt_in_if.sink                         in_i,
  lmlt_out_if.source                      out_o
);

  lmlt_pkg::cfg_t    cfg;
  lmlt_pkg::result_t step_res;
  lmlt_pkg::result_t res_q;

  logic       in_valid_q;
  logic [7:0] cycles_q;
  logic       out_valid_q;
  logic       step;
  logic       in_take;

  // the timer steps when the staged word can move into the result register
  assign step    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_take = in_i.valid && in_i.ready;
  assign in_i.ready = !in_valid_q || step;

  lmlt_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  lmlt_timer u_timer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .cycles_i (cycles_q),
    .cfg_i    (cfg),
    .res_o    (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cycles_q <= in_i.elapsed_cycles;
    end
    if (step) begin
      res_q <= step_res;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.lcd_mode        = res_q.lcd_mode;
  assign out_o.line_now        = res_q.line_now;
  assign out_o.compare_match   = res_q.compare_match;
  assign out_o.stat_irq        = res_q.stat_irq;
  assign out_o.vblank_irq      = res_q.vblank_irq;
  assign out_o.draw_background = res_q.draw_background;
  assign out_o.draw_sprites    = res_q.draw_sprites;
  assign out_o.drawn_line      = res_q.drawn_line;

endmodule
